// ----- hdl/css_pkg.sv -----
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants for the closed syncmer selector.
// ----------------------------------------------------------------------------
package css_pkg;

    // Fixed field widths
    localparam int HASH_BITS    = 64;
    localparam int POS_OUT_BITS = 32;
    localparam int COUNT_BITS   = 32;
    localparam int CFG_BITS     = 6;

    // Result tdata: hash, k-mer start, s-mer position, count
    localparam int M_TDATA_BITS = HASH_BITS + 2 * POS_OUT_BITS + COUNT_BITS;

    // Reset value of the window size register
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 6'd16;

    // Defaults for the top level parameters
    localparam int DEFAULT_MAX_WINDOW    = 32;
    localparam int DEFAULT_POSITION_BITS = 32;

    // Saturation value of the syncmer count
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Comparison token handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic [HASH_BITS-1:0] best;
    } tok_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_FINISH
    } state_t;

endpackage

// ----- hdl/css_cell.sv -----
// ----------------------------------------------------------------------------
// css_cell
// One window cell: holds the hash of one age and updates the running minimum
// token as it passes. Older cells win ties.
// ----------------------------------------------------------------------------
module css_cell import css_pkg::*; #(
    parameter int IDX_BITS   = 5,
    parameter int CELL_INDEX = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift_en,
    input  logic                 flush,
    input  logic [HASH_BITS-1:0] hash_in,
    output logic [HASH_BITS-1:0] hash_out,
    input  tok_t                 tok_in,
    input  logic [IDX_BITS-1:0]  age_in,
    output tok_t                 tok_out,
    output logic [IDX_BITS-1:0]  age_out
);

    logic [HASH_BITS-1:0] hash_reg;
    logic                 tok_valid_reg;
    logic                 tok_valid_next;
    logic [HASH_BITS-1:0] tok_best_reg;
    logic [HASH_BITS-1:0] tok_best_next;
    logic [IDX_BITS-1:0]  age_reg;
    logic [IDX_BITS-1:0]  age_next;
    logic                 take;

    // Hash shift line, moves one age on each input transfer
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            hash_reg <= hash_in;
        end
    end

    // Minimum update: equal or smaller hash in an older cell takes over
    always_comb begin
        take           = (hash_reg <= tok_in.best);
        tok_valid_next = tok_in.valid && !flush;
        tok_best_next  = take ? hash_reg : tok_in.best;
        age_next       = take ? IDX_BITS'(CELL_INDEX) : age_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok_best_reg <= tok_best_next;
        age_reg      <= age_next;
    end

    assign hash_out      = hash_reg;
    assign tok_out.valid = tok_valid_reg;
    assign tok_out.best  = tok_best_reg;
    assign age_out       = age_reg;

endmodule

// ----- hdl/css_chain.sv -----
// ----------------------------------------------------------------------------
// css_chain
// Row of window cells, newest hash in cell 0. A token seeded at cell 0 walks
// one cell per cycle; the token leaving the selected cell is returned.
// ----------------------------------------------------------------------------
module css_chain import css_pkg::*; #(
    parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW,
    parameter int IDX_BITS   = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift_en,
    input  logic [HASH_BITS-1:0] hash_in,
    input  logic                 start,
    input  logic [IDX_BITS-1:0]  sel_idx,
    output tok_t                 sel_tok,
    output logic [IDX_BITS-1:0]  sel_age
);

    tok_t                 tok_seed;
    tok_t                 tok_q  [MAX_WINDOW];
    logic [IDX_BITS-1:0]  age_q  [MAX_WINDOW];
    logic [HASH_BITS-1:0] hash_q [MAX_WINDOW];

    // Seed: all-ones so cell 0 always takes its own hash
    assign tok_seed.valid = start;
    assign tok_seed.best  = '1;

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        if (i == 0) begin : g_first
            css_cell #(
                .IDX_BITS  (IDX_BITS),
                .CELL_INDEX(i)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift_en(shift_en),
                .flush   (shift_en),
                .hash_in (hash_in),
                .hash_out(hash_q[i]),
                .tok_in  (tok_seed),
                .age_in  ('0),
                .tok_out (tok_q[i]),
                .age_out (age_q[i])
            );
        end else begin : g_next
            css_cell #(
                .IDX_BITS  (IDX_BITS),
                .CELL_INDEX(i)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift_en(shift_en),
                .flush   (shift_en),
                .hash_in (hash_q[i-1]),
                .hash_out(hash_q[i]),
                .tok_in  (tok_q[i-1]),
                .age_in  (age_q[i-1]),
                .tok_out (tok_q[i]),
                .age_out (age_q[i])
            );
        end
    end

    // Tap at the oldest cell of the current window
    assign sel_tok = tok_q[sel_idx];
    assign sel_age = age_q[sel_idx];

endmodule

// ----- hdl/closed_syncmer_selector.sv -----
// ----------------------------------------------------------------------------
// closed_syncmer_selector
// Sliding-window minimum over s-mer hashes; emits closed syncmers.
// One item is in work at a time: after an input transfer the minimum token
// walks the cell row one cell per cycle, and input is refused until the item
// is finished; finishing waits while a held result is not yet taken.
// Reset: counters clear, window size returns to 16, output empties;
// stored hashes are not cleared and are only read once rewritten.
// ----------------------------------------------------------------------------
module closed_syncmer_selector import css_pkg::*; #(
    parameter int MAX_WINDOW    = DEFAULT_MAX_WINDOW,
    parameter int POSITION_BITS = DEFAULT_POSITION_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [HASH_BITS-1:0]    s_tdata,   // [63:0] smer_hash
    input  logic                    s_tlast,   // last_smer
    // Result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,   // [63:0] syncmer_hash,
                                               // [95:64] k-mer start,
                                               // [127:96] minimum s-mer position,
                                               // [159:128] syncmer_count
    // Window size register
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    localparam int IDX_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_BITS = $clog2(MAX_WINDOW + 1);
    localparam int CMP_BITS = (POSITION_BITS > WIN_BITS) ? POSITION_BITS : WIN_BITS;

    state_t                    state_reg;
    state_t                    state_next;
    logic [CFG_BITS-1:0]       window_reg;
    logic [POSITION_BITS-1:0]  pos_cnt_reg;
    logic [POSITION_BITS-1:0]  pos_cnt_next;
    logic [POSITION_BITS-1:0]  pos_reg;
    logic                      elig_reg;
    logic                      last_reg;
    logic                      start_reg;
    logic [HASH_BITS-1:0]      best_reg;
    logic [IDX_BITS-1:0]       age_reg;
    logic                      capture;
    logic [COUNT_BITS-1:0]     found_reg;
    logic [COUNT_BITS-1:0]     found_next;
    logic [COUNT_BITS-1:0]     found_inc;
    logic                      m_tvalid_reg;
    logic                      m_tvalid_next;
    logic [M_TDATA_BITS-1:0]   m_tdata_reg;
    logic [M_TDATA_BITS-1:0]   m_tdata_next;

    logic                      accept;
    logic                      out_free;
    logic                      emit;
    logic [WIN_BITS-1:0]       w_eff;
    logic [IDX_BITS-1:0]       sel_idx;
    logic [POSITION_BITS-1:0]  pos_inc;
    logic                      elig_now;
    logic                      is_sync;
    logic [POSITION_BITS-1:0]  start_pos;
    logic [POSITION_BITS-1:0]  smer_pos;
    tok_t                      sel_tok;
    logic [IDX_BITS-1:0]       sel_age;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Effective window: zero reads as one, clipped at the row length
    always_comb begin
        if (window_reg == '0) begin
            w_eff = WIN_BITS'(1);
        end else if (32'(window_reg) > 32'(MAX_WINDOW)) begin
            w_eff = WIN_BITS'(MAX_WINDOW);
        end else begin
            w_eff = WIN_BITS'(window_reg);
        end
        sel_idx = IDX_BITS'(w_eff - WIN_BITS'(1));
    end

    // Saturating position counter and window-full check
    always_comb begin
        pos_inc  = (pos_cnt_reg != '1) ? pos_cnt_reg + POSITION_BITS'(1) : pos_cnt_reg;
        elig_now = (CMP_BITS'(pos_inc) >= CMP_BITS'(w_eff));
        pos_cnt_next = pos_cnt_reg;
        if (accept) begin
            pos_cnt_next = s_tlast ? '0 : pos_inc;
        end
    end

    css_chain #(
        .MAX_WINDOW(MAX_WINDOW),
        .IDX_BITS  (IDX_BITS)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift_en(accept),
        .hash_in (s_tdata),
        .start   (start_reg),
        .sel_idx (sel_idx),
        .sel_tok (sel_tok),
        .sel_age (sel_age)
    );

    // Result formation: minimum at the oldest or newest slot
    always_comb begin
        is_sync   = (age_reg == '0) || (age_reg == sel_idx);
        start_pos = pos_reg - POSITION_BITS'(sel_idx);
        smer_pos  = pos_reg - POSITION_BITS'(age_reg);
        found_inc = (found_reg != COUNT_MAX) ? found_reg + COUNT_BITS'(1) : found_reg;
    end

    // Controller: next state, capture and output register
    always_comb begin
        state_next    = state_reg;
        capture       = 1'b0;
        emit          = 1'b0;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (sel_tok.valid) begin
                    capture    = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    if (elig_reg && is_sync) begin
                        emit          = 1'b1;
                        found_next    = found_inc;
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = {found_inc, POS_OUT_BITS'(smer_pos),
                                         POS_OUT_BITS'(start_pos), best_reg};
                    end
                    if (last_reg) begin
                        found_next = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            window_reg   <= WINDOW_RESET;
            pos_cnt_reg  <= '0;
            found_reg    <= '0;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_cnt_reg  <= pos_cnt_next;
            found_reg    <= found_next;
            start_reg    <= accept;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                window_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_reg  <= pos_cnt_reg;
            elig_reg <= elig_now;
            last_reg <= s_tlast;
        end
        if (capture) begin
            best_reg <= sel_tok.best;
            age_reg  <= sel_age;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A transfer in starts work: no second transfer in the next cycle
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in work");

    // Every result carries a non-zero running count
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_BITS-1:M_TDATA_BITS-COUNT_BITS] != '0))
        else $error("result with zero syncmer count");

    // New results are only loaded from the finishing state
    a_emit_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result issued outside the finishing state");

    // A result load never happens in the same cycle as a capture
    a_capture_order: assert property (@(posedge aclk) disable iff (!aresetn)
        capture |-> !emit)
        else $error("capture and result load in one cycle");

endmodule

// ----- tb/closed_syncmer_selector_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closed_syncmer_selector_tb
// Self-checking bench for the closed syncmer selector. A tracker class keeps
// its own copy of the hash ring, the position and syncmer counters and the
// window size. It predicts each syncmer from the accepted hashes and checks
// the result stream field by field. Directed sequences cover small windows,
// the hash extremes, ties and short sequences. Random phases then change the window
// size, sometimes in the middle of a sequence, under varying back-pressure.
// ----------------------------------------------------------------------------
module closed_syncmer_selector_tb;
    import css_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 48;     // lets the last item finish, also at W = 32
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_PHASES       = 12;
    localparam int PHASE_ITEMS    = 56;

    // Hash styles for random sequences
    localparam int HS_WIDE    = 0;
    localparam int HS_NARROW  = 1;
    localparam int HS_EXTREME = 2;
    localparam int HS_RISING  = 3;
    localparam int HS_FALLING = 4;

    typedef struct packed {
        logic [COUNT_BITS-1:0]   count;
        logic [POS_OUT_BITS-1:0] smer_pos;
        logic [POS_OUT_BITS-1:0] start_pos;
        logic [HASH_BITS-1:0]    hash;
    } syncmer_t;

    // ------------------------------------------------------------------------
    // Tracker: predicts closed syncmers and checks the result stream
    // ------------------------------------------------------------------------
    class syncmer_tracker;
        logic [HASH_BITS-1:0]    hash_ring [DEFAULT_MAX_WINDOW];
        int unsigned             ring_slot = 0;
        logic [31:0]             seen_count = '0;
        logic [COUNT_BITS-1:0]   found_count = '0;
        logic [CFG_BITS-1:0]     window_reg = WINDOW_RESET;
        syncmer_t                expected_syncmers [$];
        int unsigned             mismatches = 0;

        function void set_window(logic [CFG_BITS-1:0] value);
            window_reg = value;
        endfunction

        // Zero reads as one, anything above the ring depth as the ring depth
        function int unsigned window_len();
            int unsigned w;
            w = 32'(window_reg);
            if (w == 0) w = 1;
            if (w > DEFAULT_MAX_WINDOW) w = DEFAULT_MAX_WINDOW;
            return w;
        endfunction

        function int unsigned pending();
            return expected_syncmers.size();
        endfunction

        // Accepted hash: update the window and queue a syncmer if one is due
        function void note_hash(logic [HASH_BITS-1:0] h, bit last);
            int unsigned w, slot, oldest, best_off;
            logic [31:0] cur_pos, kpos;
            logic [HASH_BITS-1:0] best, v;
            syncmer_t sm;
            w       = window_len();
            cur_pos = seen_count;
            slot    = ring_slot;
            hash_ring[slot] = h;
            ring_slot = (slot + 1) % DEFAULT_MAX_WINDOW;
            if (seen_count != '1) seen_count = seen_count + 1;
            if (seen_count >= w) begin
                oldest   = (slot + DEFAULT_MAX_WINDOW + 1 - w) % DEFAULT_MAX_WINDOW;
                best     = hash_ring[oldest];
                best_off = 0;
                for (int unsigned off = 1; off < w; off++) begin
                    v = hash_ring[(oldest + off) % DEFAULT_MAX_WINDOW];
                    // strict compare keeps the earliest on ties
                    if (v < best) begin
                        best     = v;
                        best_off = off;
                    end
                end
                if (best_off == 0 || best_off == w - 1) begin
                    kpos = cur_pos - (w - 1);
                    if (found_count != COUNT_MAX) found_count = found_count + 1;
                    sm.hash      = best;
                    sm.start_pos = kpos;
                    sm.smer_pos  = kpos + best_off;
                    sm.count     = found_count;
                    expected_syncmers.push_back(sm);
                end
            end
            if (last) begin
                seen_count  = '0;
                found_count = '0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task check_syncmer(logic [M_TDATA_BITS-1:0] data);
            syncmer_t got, want;
            got.hash      = data[63:0];
            got.start_pos = data[95:64];
            got.smer_pos  = data[127:96];
            got.count     = data[159:128];
            if (expected_syncmers.size() == 0) begin
                report_mismatch($sformatf("unexpected result hash %h start %0d",
                                          got.hash, got.start_pos));
            end else begin
                want = expected_syncmers.pop_front();
                if (got.hash !== want.hash)
                    report_mismatch($sformatf("syncmer_hash got %h want %h",
                                              got.hash, want.hash));
                if (got.start_pos !== want.start_pos)
                    report_mismatch($sformatf("k-mer start got %0d want %0d",
                                              got.start_pos, want.start_pos));
                if (got.smer_pos !== want.smer_pos)
                    report_mismatch($sformatf("minimum s-mer position got %0d want %0d",
                                              got.smer_pos, want.smer_pos));
                if (got.count !== want.count)
                    report_mismatch($sformatf("syncmer_count got %0d want %0d",
                                              got.count, want.count));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [HASH_BITS-1:0]    s_tdata = '0;   // [63:0] smer_hash
    logic                    s_tlast = 1'b0; // last_smer
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;        // [63:0] syncmer_hash, [95:64] k-mer start,
                                             // [127:96] minimum s-mer position,
                                             // [159:128] syncmer_count
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_BITS-1:0]     cfg_data = '0;

    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     quiet_cycles   = 0;
    syncmer_tracker  tracker;

    closed_syncmer_selector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Result side: check transfers, random back-pressure, activity count
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
            m_tready     <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) tracker.check_syncmer(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: no transfer of any kind for too long
    initial begin
        @(posedge aclk);
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_hash(input logic [HASH_BITS-1:0] h, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= h;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_hash(h, last);
    endtask

    // Window size changes only once the block has drained
    task automatic write_window(input logic [CFG_BITS-1:0] value);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tracker.set_window(value);
    endtask

    function automatic logic [HASH_BITS-1:0] pick_hash(int style, int idx,
                                                      logic [HASH_BITS-1:0] base);
        logic [HASH_BITS-1:0] h;
        case (style)
            HS_NARROW:  h = 64'($urandom_range(3));
            HS_EXTREME: begin
                case ($urandom_range(3))
                    0:       h = '0;
                    1:       h = '1;
                    2:       h = {1'b1, 63'($urandom_range(7))};
                    default: h = {$urandom, $urandom};
                endcase
            end
            HS_RISING:  h = base + 64'(idx);
            HS_FALLING: h = base - 64'(idx);
            default:    h = {$urandom, $urandom};
        endcase
        return h;
    endfunction

    // One sequence of random content; a few stray last flags break it up
    task automatic send_sequence(input int len, input bit close);
        int style;
        logic [HASH_BITS-1:0] base;
        bit last;
        style = $urandom_range(HS_FALLING);
        base  = {$urandom, $urandom};
        for (int i = 0; i < len; i++) begin
            last = (close && i == len - 1) || ($urandom_range(99) < 2);
            send_hash(pick_hash(style, i, base), last);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_BITS-1:0] windows [N_PHASES];
        int unsigned budget, w, len;
        bit close;

        windows = '{6'd1, 6'd2, 6'd32, 6'd33, 6'd63, 6'd0, 6'd5, 6'd16, 6'd8, 6'd31,
                    6'd3, 6'd12};
        tracker = new;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: window of one, every s-mer is a syncmer
        write_window(6'd1);
        send_hash('0, 1'b0);
        send_hash('1, 1'b0);
        send_hash(64'd5, 1'b1);

        // Window of three: ties, minimum at either end and in the middle
        write_window(6'd3);
        send_hash(64'd7, 1'b0);
        send_hash(64'd7, 1'b0);
        send_hash(64'd7, 1'b0);
        send_hash(64'd5, 1'b0);
        send_hash(64'd9, 1'b0);
        send_hash(64'd9, 1'b1);
        // sequence shorter than the window yields nothing
        send_hash(64'd1, 1'b0);
        send_hash(64'd2, 1'b1);

        // Window of two across the hash extremes
        write_window(6'd2);
        send_hash('1, 1'b0);
        send_hash('0, 1'b0);
        send_hash('1, 1'b1);

        // Window zero reads as one
        write_window(6'd0);
        send_hash('1, 1'b0);
        send_hash('0, 1'b1);

        // Window size change in the middle of a sequence
        write_window(6'd4);
        send_hash(64'd40, 1'b0);
        send_hash(64'd30, 1'b0);
        send_hash(64'd20, 1'b0);
        write_window(6'd2);
        send_hash(64'd10, 1'b0);
        send_hash(64'd50, 1'b1);

        // Random phases over window sizes and idle patterns
        for (int p = 0; p < N_PHASES; p++) begin
            write_window(windows[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            budget = PHASE_ITEMS;
            while (budget > 0) begin
                w = tracker.window_len();
                if ($urandom_range(9) == 0)
                    len = $urandom_range(w, 1);
                else
                    len = $urandom_range(3 * w + 8, w);
                if (len > budget) len = budget;
                budget = budget - len;
                // the last sequence of a phase may run on into the next one
                close = (budget > 0) || ($urandom_range(1) == 1);
                send_sequence(len, close);
            end
        end

        // Drain
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
